// ===== rtl/core/signed_joint_angle_from_keypoints_unit_defines.svh =====
// assertion macros shared by the joint angle rtl
// every macro samples on clk and is disabled while rst is high
`ifndef SIGNED_JOINT_ANGLE_FROM_KEYPOINTS_UNIT_DEFINES_SVH
`define SIGNED_JOINT_ANGLE_FROM_KEYPOINTS_UNIT_DEFINES_SVH

// same-cycle implication
`define SJAK_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SJAK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/sjak_pkg.sv =====
package sjak_pkg;

  // field widths fixed by the beat formats
  localparam int COORD_BITS = 12;
  localparam int ANGLE_BITS = 16;
  localparam int LIMIT_BITS = 15;

  // register indexes
  localparam logic REG_SHOULDER_LIMIT = 1'b0;
  localparam logic REG_ELBOW_LIMIT    = 1'b1;

  // register reset values, 32768 = pi
  localparam logic [LIMIT_BITS-1:0] SHOULDER_LIMIT_RST = 15'd14564;
  localparam logic [LIMIT_BITS-1:0] ELBOW_LIMIT_RST    = 15'd21845;

  // arithmetic widths
  localparam int DIFF_W      = COORD_BITS + 1;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int SUM_W       = PROD_W + 1;
  localparam int GUARD_SHIFT = 24;
  localparam int CORDIC_W    = 2 * COORD_BITS + 28;
  localparam int Z_W         = 34;
  localparam int Z_MAG_W     = 32;
  localparam int ROUND_SHIFT = Z_MAG_W - ANGLE_BITS;
  localparam int TABLE_LEN   = 24;

  // accumulator scale: pi = 2^31
  localparam logic signed [Z_W-1:0] Z_PI      = 34'sd2147483648;
  localparam logic signed [Z_W-1:0] Z_HALF_PI = 34'sd1073741824;

  // atan(2^-i) in accumulator units
  localparam logic signed [Z_W-1:0] ATAN_TAB [TABLE_LEN] = '{
    34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
    34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
    34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
    34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
    34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
    34'sd652,       34'sd326,       34'sd163,       34'sd81
  };

  typedef struct packed {
    logic                  kind;
    logic [COORD_BITS-1:0] first_x;
    logic [COORD_BITS-1:0] first_y;
    logic [COORD_BITS-1:0] middle_x;
    logic [COORD_BITS-1:0] middle_y;
    logic [COORD_BITS-1:0] last_x;
    logic [COORD_BITS-1:0] last_y;
  } joint_t;

  typedef struct packed {
    logic                         valid_res;
    logic                         degenerate;
    logic                         clamped;
    logic signed [ANGLE_BITS-1:0] joint_angle;
  } result_t;

  // per-item flags carried alongside the arithmetic
  typedef struct packed {
    logic valid_res;
    logic degenerate;
    logic kind;
    logic neg;
  } side_t;

endpackage

// ===== rtl/core/sjak_cordic.sv =====
`include "signed_joint_angle_from_keypoints_unit_defines.svh"

module sjak_cordic #(
  parameter int STAGES = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  input  logic signed [sjak_pkg::CORDIC_W-1:0]   in_x,
  input  logic signed [sjak_pkg::CORDIC_W-1:0]   in_y,
  input  logic signed [sjak_pkg::Z_W-1:0]        in_z,
  input  sjak_pkg::side_t                        in_side,
  output logic                                   out_valid,
  output logic signed [sjak_pkg::Z_W-1:0]        out_z,
  output sjak_pkg::side_t                        out_side
);

  logic signed [sjak_pkg::CORDIC_W-1:0] xs [0:STAGES];
  logic signed [sjak_pkg::CORDIC_W-1:0] ys [0:STAGES];
  logic signed [sjak_pkg::Z_W-1:0]      zs [0:STAGES];
  sjak_pkg::side_t                      sides [0:STAGES];
  logic                                 valids [0:STAGES];

  assign xs[0]     = in_x;
  assign ys[0]     = in_y;
  assign zs[0]     = in_z;
  assign sides[0]  = in_side;
  assign valids[0] = in_valid;

  // one vectoring iteration per register stage
  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        valids[i+1] <= 1'b0;
      end else begin
        valids[i+1] <= valids[i];
      end
    end

    always_ff @(posedge clk) begin
      sides[i+1] <= sides[i];
      if (!ys[i][sjak_pkg::CORDIC_W-1]) begin
        xs[i+1] <= xs[i] + (ys[i] >>> i);
        ys[i+1] <= ys[i] - (xs[i] >>> i);
        zs[i+1] <= zs[i] + sjak_pkg::ATAN_TAB[i];
      end else begin
        xs[i+1] <= xs[i] - (ys[i] >>> i);
        ys[i+1] <= ys[i] + (xs[i] >>> i);
        zs[i+1] <= zs[i] - sjak_pkg::ATAN_TAB[i];
      end
    end
  end

  assign out_valid = valids[STAGES];
  assign out_z     = zs[STAGES];
  assign out_side  = sides[STAGES];

  // x only grows in vectoring mode, a negative x means a wrapped adder
  `SJAK_ASSERT_IMP(a_x_nonneg, out_valid, !xs[STAGES][sjak_pkg::CORDIC_W-1], "cordic x wrapped")

endmodule

// ===== rtl/core/signed_joint_angle_from_keypoints_unit.sv =====
// Signed joint angle from three keypoints. One joint beat is taken on every
// clock edge where start is high and busy is low; busy is high only while rst
// is asserted. The datapath is a straight pipeline of CORDIC_STAGES + 6
// register stages (capped at 24 CORDIC iterations): four front stages for
// differences, products, dot/cross sums and pre-rotation, one unrolled CORDIC
// iteration per stage, then rounding and limiting. A result beat therefore
// appears on result with done high, one result per joint, in order, at up to
// one per cycle. done is high for one cycle only and cannot be held off, so
// the receiver must take every result beat as it comes. Limits are written
// through wr_en / wr_index / wr_data and should only change while no joint is
// in flight.
`include "signed_joint_angle_from_keypoints_unit_defines.svh"

module signed_joint_angle_from_keypoints_unit #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  sjak_pkg::joint_t                  joint,
  output logic                              done,
  output sjak_pkg::result_t                 result,
  input  logic                              wr_en,
  input  logic                              wr_index,
  input  logic [sjak_pkg::LIMIT_BITS-1:0]   wr_data
);

  localparam int NUM_STAGES = (CORDIC_STAGES < sjak_pkg::TABLE_LEN) ?
                              CORDIC_STAGES : sjak_pkg::TABLE_LEN;
  localparam int LATENCY    = NUM_STAGES + 6;

  localparam int DW = sjak_pkg::DIFF_W;
  localparam int PW = sjak_pkg::PROD_W;
  localparam int SW = sjak_pkg::SUM_W;
  localparam int CW = sjak_pkg::CORDIC_W;
  localparam int ZW = sjak_pkg::Z_W;
  localparam int AW = sjak_pkg::ANGLE_BITS;
  localparam int MW = sjak_pkg::Z_MAG_W;

  localparam logic [AW-1:0] ANG_TOP = {1'b0, {(AW-1){1'b1}}};
  localparam logic [MW-1:0] ROUND_HALF = MW'(1) << (sjak_pkg::ROUND_SHIFT - 1);

  logic [sjak_pkg::LIMIT_BITS-1:0] shoulder_limit;
  logic [sjak_pkg::LIMIT_BITS-1:0] elbow_limit;

  assign busy = rst;

  // limit registers
  always_ff @(posedge clk) begin
    if (rst) begin
      shoulder_limit <= sjak_pkg::SHOULDER_LIMIT_RST;
      elbow_limit    <= sjak_pkg::ELBOW_LIMIT_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        sjak_pkg::REG_SHOULDER_LIMIT: shoulder_limit <= wr_data;
        sjak_pkg::REG_ELBOW_LIMIT:    elbow_limit    <= wr_data;
        default: ;
      endcase
    end
  end

  // ---------------- stage a: differences and flags ----------------
  logic                 a_valid;
  sjak_pkg::side_t      a_side;
  logic signed [DW-1:0] a_ux, a_uy, a_vx, a_vy, a_ax, a_ay;

  logic signed [DW-1:0] fx, fy, mx, my, lx, ly;
  logic                 missing, coincide;

  always_comb begin
    fx = $signed({1'b0, joint.first_x});
    fy = $signed({1'b0, joint.first_y});
    mx = $signed({1'b0, joint.middle_x});
    my = $signed({1'b0, joint.middle_y});
    lx = $signed({1'b0, joint.last_x});
    ly = $signed({1'b0, joint.last_y});
    missing  = (joint.first_x == '0 && joint.first_y == '0) ||
               (joint.middle_x == '0 && joint.middle_y == '0) ||
               (joint.last_x == '0 && joint.last_y == '0);
    coincide = (joint.first_x == joint.last_x && joint.first_y == joint.last_y) ||
               (joint.first_x == joint.middle_x && joint.first_y == joint.middle_y) ||
               (joint.middle_x == joint.last_x && joint.middle_y == joint.last_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    a_side.valid_res  <= !missing;
    a_side.degenerate <= !missing && coincide;
    a_side.kind       <= joint.kind;
    a_side.neg        <= 1'b0;
    a_ux <= fx - mx;
    a_uy <= fy - my;
    a_vx <= mx - lx;
    a_vy <= my - ly;
    a_ax <= fx - lx;
    a_ay <= fy - ly;
  end

  // ---------------- stage b: products ----------------
  logic                 b_valid;
  sjak_pkg::side_t      b_side;
  logic signed [PW-1:0] b_uxvx, b_uyvy, b_uxvy, b_uyvx, b_vxay, b_vyax;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    b_side <= a_side;
    b_uxvx <= PW'(a_ux) * PW'(a_vx);
    b_uyvy <= PW'(a_uy) * PW'(a_vy);
    b_uxvy <= PW'(a_ux) * PW'(a_vy);
    b_uyvx <= PW'(a_uy) * PW'(a_vx);
    b_vxay <= PW'(a_vx) * PW'(a_ay);
    b_vyax <= PW'(a_vy) * PW'(a_ax);
  end

  // ---------------- stage c: dot, cross and side ----------------
  logic                 c_valid;
  sjak_pkg::side_t      c_side;
  logic signed [SW-1:0] c_dot, c_crs;

  logic signed [SW-1:0] side_val;
  logic                 side_pos, side_negv;

  always_comb begin
    side_val  = SW'(b_vxay) - SW'(b_vyax);
    side_negv = side_val[SW-1];
    side_pos  = (side_val != '0) && !side_negv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    c_side.valid_res  <= b_side.valid_res;
    c_side.degenerate <= b_side.degenerate;
    c_side.kind       <= b_side.kind;
    c_side.neg        <= b_side.kind ? side_negv : side_pos;
    c_dot             <= SW'(b_uxvx) + SW'(b_uyvy);
    c_crs             <= SW'(b_uxvy) - SW'(b_uyvx);
  end

  // ---------------- stage d: pre-rotation and scaling ----------------
  logic                 d_valid;
  sjak_pkg::side_t      d_side;
  logic signed [CW-1:0] d_x, d_y;
  logic signed [ZW-1:0] d_z;

  logic signed [SW-1:0] crs_abs, x_pre, y_pre;
  logic                 dot_neg;

  always_comb begin
    crs_abs = c_crs[SW-1] ? -c_crs : c_crs;
    dot_neg = c_dot[SW-1];
    x_pre   = dot_neg ? crs_abs : c_dot;
    y_pre   = dot_neg ? -c_dot : crs_abs;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    d_side <= c_side;
    d_x    <= CW'(x_pre) <<< sjak_pkg::GUARD_SHIFT;
    d_y    <= CW'(y_pre) <<< sjak_pkg::GUARD_SHIFT;
    d_z    <= dot_neg ? sjak_pkg::Z_HALF_PI : '0;
  end

  // ---------------- cordic iterations ----------------
  logic                 k_valid;
  logic signed [ZW-1:0] k_z;
  sjak_pkg::side_t      k_side;

  sjak_cordic #(
    .STAGES (NUM_STAGES)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d_valid),
    .in_x      (d_x),
    .in_y      (d_y),
    .in_z      (d_z),
    .in_side   (d_side),
    .out_valid (k_valid),
    .out_z     (k_z),
    .out_side  (k_side)
  );

  // ---------------- stage e: clamp to [0, pi] and round ----------------
  logic            e_valid;
  sjak_pkg::side_t e_side;
  logic [AW-1:0]   e_mag;

  logic [MW-1:0] z_clip, z_rnd;

  always_comb begin
    if (k_z[ZW-1]) begin
      z_clip = '0;
    end else if (k_z > sjak_pkg::Z_PI) begin
      z_clip = MW'(sjak_pkg::Z_PI);
    end else begin
      z_clip = MW'(k_z);
    end
    z_rnd = z_clip + ROUND_HALF;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else begin
      e_valid <= k_valid;
    end
  end

  always_ff @(posedge clk) begin
    e_side <= k_side;
    e_mag  <= z_rnd[MW-1:sjak_pkg::ROUND_SHIFT];
  end

  // ---------------- stage f: sign, limit, saturate ----------------
  logic [AW-1:0]     lim_ext;
  sjak_pkg::result_t res_next;

  always_comb begin
    lim_ext  = AW'(e_side.kind ? elbow_limit : shoulder_limit);
    res_next = '0;
    if (e_side.valid_res && e_side.degenerate) begin
      res_next.valid_res  = 1'b1;
      res_next.degenerate = 1'b1;
    end else if (e_side.valid_res) begin
      res_next.valid_res = 1'b1;
      if (e_mag > lim_ext) begin
        res_next.clamped     = 1'b1;
        res_next.joint_angle = e_side.neg ? -$signed(lim_ext) : $signed(lim_ext);
      end else if (!e_side.neg && e_mag > ANG_TOP) begin
        res_next.joint_angle = $signed(ANG_TOP);
      end else begin
        res_next.joint_angle = e_side.neg ? -$signed(e_mag) : $signed(e_mag);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    result <= res_next;
  end

  // ---------------- checks ----------------
  `SJAK_ASSERT_NEXT(a_lat_fwd, start && !busy, ##(LATENCY-1) done, "result beat missing")
  `SJAK_ASSERT_IMP(a_lat_back, done, $past(start && !busy, LATENCY), "result beat without joint")
  `SJAK_ASSERT_IMP(a_missing_zero, done && !result.valid_res, result == '0, "missing joint not zero")
  `SJAK_ASSERT_IMP(a_degen_zero, done && result.degenerate, result.joint_angle == '0 && !result.clamped, "degenerate angle not zero")

endmodule

// ===== sim/signed_joint_angle_from_keypoints_unit_test.sv =====
`timescale 1ns / 1ps

module signed_joint_angle_from_keypoints_unit_test;

  localparam int STAGES           = 16;
  localparam int LATENCY          = STAGES + 6;
  localparam int CYCLE_LIMIT      = 400000;
  localparam int RANDOM_PER_PHASE = 120;
  localparam int LIMIT_MAX        = 32767;

  // atan(2^-i) with pi = 2^31
  localparam longint ATAN_STEP [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  // joint beat with the idle cycles that follow it
  typedef struct {
    sjak_pkg::joint_t beat;
    int unsigned      pause;
  } pending_t;

  logic                            clk      = 1'b0;
  logic                            rst      = 1'b1;
  logic                            start    = 1'b0;
  logic                            busy;
  sjak_pkg::joint_t                joint    = '0;
  logic                            done;
  sjak_pkg::result_t               result;
  logic                            wr_en    = 1'b0;
  logic                            wr_index = 1'b0;
  logic [sjak_pkg::LIMIT_BITS-1:0] wr_data  = '0;

  pending_t          pending[$];
  sjak_pkg::result_t angle_due[$];

  // local copy of the limit registers
  logic [sjak_pkg::LIMIT_BITS-1:0] shoulder_lim = sjak_pkg::SHOULDER_LIMIT_RST;
  logic [sjak_pkg::LIMIT_BITS-1:0] elbow_lim    = sjak_pkg::ELBOW_LIMIT_RST;

  int          errors    = 0;
  int          checked   = 0;
  int          n_missing = 0;
  int          n_degen   = 0;
  int          n_clamped = 0;
  int          settings  = 1;
  int unsigned hold      = 0;
  int unsigned calm_left = 0;

  signed_joint_angle_from_keypoints_unit #(
    .CORDIC_STAGES(STAGES)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .joint   (joint),
    .done    (done),
    .result  (result),
    .wr_en   (wr_en),
    .wr_index(wr_index),
    .wr_data (wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  // signed joint angle of one beat under the current limits
  function automatic sjak_pkg::result_t angle_of_joint(input sjak_pkg::joint_t j);
    sjak_pkg::result_t r;
    longint  fx, fy, mx, my, lx, ly;
    longint  ux, uy, vx, vy, ax, ay;
    longint  dt, cr, sd, x, y, z, xs, ys, ang, lim;
    r  = '0;
    fx = j.first_x;
    fy = j.first_y;
    mx = j.middle_x;
    my = j.middle_y;
    lx = j.last_x;
    ly = j.last_y;
    if ((fx == 0 && fy == 0) || (mx == 0 && my == 0) || (lx == 0 && ly == 0))
      return r;
    r.valid_res = 1'b1;
    if ((fx == lx && fy == ly) || (fx == mx && fy == my) || (mx == lx && my == ly)) begin
      r.degenerate = 1'b1;
      return r;
    end
    ux = fx - mx;
    uy = fy - my;
    vx = mx - lx;
    vy = my - ly;
    ax = fx - lx;
    ay = fy - ly;
    dt = ux * vx + uy * vy;
    cr = ux * vy - uy * vx;
    if (cr < 0)
      cr = -cr;
    sd = vx * ay - vy * ax;
    // pre-rotate by -pi/2 when the dot is negative
    if (dt < 0) begin
      x = cr;
      y = -dt;
      z = 64'sd1073741824;
    end else begin
      x = dt;
      y = cr;
      z = 0;
    end
    x = x <<< 24;
    y = y <<< 24;
    // vectoring iterations
    for (int i = 0; i < STAGES && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_STEP[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_STEP[i];
      end
    end
    if (z < 0)
      z = 0;
    if (z > 64'sd2147483648)
      z = 64'sd2147483648;
    ang = (z + 64'sd32768) >>> 16;
    // sign from the side of the turn
    if ((!j.kind && sd > 0) || (j.kind && sd < 0))
      ang = -ang;
    lim = j.kind ? longint'(elbow_lim) : longint'(shoulder_lim);
    if (ang > lim) begin
      ang = lim;
      r.clamped = 1'b1;
    end else if (ang < -lim) begin
      ang = -lim;
      r.clamped = 1'b1;
    end
    if (ang > 32767)
      ang = 32767;
    if (ang < -32768)
      ang = -32768;
    r.joint_angle = ang[sjak_pkg::ANGLE_BITS-1:0];
    return r;
  endfunction

  function automatic sjak_pkg::joint_t keypoints(input int k, input int fx, input int fy,
                                                 input int mx, input int my,
                                                 input int lx, input int ly);
    sjak_pkg::joint_t j;
    j.kind     = k[0];
    j.first_x  = fx[sjak_pkg::COORD_BITS-1:0];
    j.first_y  = fy[sjak_pkg::COORD_BITS-1:0];
    j.middle_x = mx[sjak_pkg::COORD_BITS-1:0];
    j.middle_y = my[sjak_pkg::COORD_BITS-1:0];
    j.last_x   = lx[sjak_pkg::COORD_BITS-1:0];
    j.last_y   = ly[sjak_pkg::COORD_BITS-1:0];
    return j;
  endfunction

  // queue a joint beat, choosing the idle gap after it
  task automatic queue_item(input sjak_pkg::joint_t j);
    pending_t    p;
    int unsigned r;
    p.beat = j;
    if (calm_left != 0) begin
      calm_left--;
      p.pause = 0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        calm_left = $urandom_range(10, 40);
        p.pause   = 0;
      end else if (r < 50) begin
        p.pause = 0;
      end else if (r < 85) begin
        p.pause = $urandom_range(1, 3);
      end else if (r < 97) begin
        p.pause = $urandom_range(4, 12);
      end else begin
        p.pause = $urandom_range(20, 60);
      end
    end
    pending.insert(pending.size(), p);
  endtask

  task automatic write_limit(input logic idx, input int val);
    @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val[sjak_pkg::LIMIT_BITS-1:0];
    @(posedge clk);
    wr_en <= 1'b0;
    if (idx == sjak_pkg::REG_SHOULDER_LIMIT)
      shoulder_lim = val[sjak_pkg::LIMIT_BITS-1:0];
    else
      elbow_lim = val[sjak_pkg::LIMIT_BITS-1:0];
  endtask

  // block idle: nothing queued, nothing offered, nothing in flight
  task automatic wait_drained();
    @(negedge clk);
    while (pending.size() != 0 || start || angle_due.size() != 0)
      @(negedge clk);
  endtask

  // driver: offer queued joints, then idle for the chosen gap
  always @(posedge clk) begin : drive
    pending_t nxt;
    if (rst) begin
      start <= 1'b0;
      hold  <= 0;
    end else if (!start || !busy) begin
      if (hold != 0) begin
        start <= 1'b0;
        hold  <= hold - 1;
      end else if (pending.size() != 0) begin
        nxt = pending.pop_front();
        joint <= nxt.beat;
        start <= 1'b1;
        hold  <= nxt.pause;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: predict on acceptance, check each result beat
  always @(posedge clk) begin : watch
    sjak_pkg::result_t want;
    if (!rst) begin
      if (start && !busy)
        angle_due.insert(angle_due.size(), angle_of_joint(joint));
      if (done) begin
        if (angle_due.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing expected: valid %0b degen %0b clamp %0b angle %0d",
                   $time, result.valid_res, result.degenerate, result.clamped,
                   result.joint_angle);
        end else begin
          want = angle_due.pop_front();
          checked++;
          if (!want.valid_res)
            n_missing++;
          if (want.degenerate)
            n_degen++;
          if (want.clamped)
            n_clamped++;
          if (result.valid_res !== want.valid_res || result.degenerate !== want.degenerate ||
              result.clamped !== want.clamped || result.joint_angle !== want.joint_angle) begin
            errors++;
            $display("%0t: mismatch: expected valid %0b degen %0b clamp %0b angle %0d",
                     $time, want.valid_res, want.degenerate, want.clamped, want.joint_angle);
            $display("%0t:           actual valid %0b degen %0b clamp %0b angle %0d",
                     $time, result.valid_res, result.degenerate, result.clamped,
                     result.joint_angle);
          end
        end
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    sjak_pkg::joint_t j;
    logic [95:0]      bits;
    int               r, which, s, e, mx, my, dx, dy, a, b;
    @(negedge clk);
    while (rst)
      @(negedge clk);

    // directed beats under the reset limits
    queue_item(keypoints(0, 0, 0, 200, 300, 400, 100));
    queue_item(keypoints(1, 100, 100, 0, 0, 400, 100));
    queue_item(keypoints(0, 100, 100, 200, 300, 0, 0));
    queue_item(keypoints(1, 0, 500, 200, 300, 400, 0));
    queue_item(keypoints(0, 100, 100, 200, 150, 100, 100));
    queue_item(keypoints(1, 321, 654, 321, 654, 900, 10));
    queue_item(keypoints(0, 4095, 4095, 7, 9, 7, 9));
    queue_item(keypoints(0, 4095, 4095, 1, 1, 4095, 1));
    queue_item(keypoints(1, 4095, 4095, 1, 1, 4095, 1));
    queue_item(keypoints(0, 1, 4095, 4095, 1, 1, 1));
    queue_item(keypoints(1, 4095, 0, 0, 4095, 4095, 4095));
    queue_item(keypoints(0, 10, 10, 20, 20, 30, 30));
    queue_item(keypoints(0, 10, 10, 30, 10, 20, 10));
    queue_item(keypoints(1, 10, 10, 30, 10, 20, 10));
    queue_item(keypoints(0, 100, 100, 100, 300, 300, 300));
    queue_item(keypoints(0, 300, 300, 100, 300, 100, 100));
    queue_item(keypoints(1, 100, 100, 100, 300, 300, 300));
    queue_item(keypoints(1, 300, 300, 100, 300, 100, 100));
    queue_item(keypoints(0, 100, 100, 200, 110, 300, 100));
    queue_item(keypoints(0, 300, 100, 200, 110, 100, 100));
    queue_item(keypoints(1, 100, 100, 200, 110, 300, 100));
    queue_item(keypoints(1, 300, 100, 200, 110, 100, 100));

    // random phases, each under its own pair of limits
    for (int p = 0; p < 5; p++) begin
      wait_drained();
      case (p)
        0: begin
          s = 0;
          e = LIMIT_MAX;
        end
        1: begin
          s = LIMIT_MAX;
          e = 0;
        end
        2: begin
          s = $urandom_range(0, LIMIT_MAX);
          e = $urandom_range(0, LIMIT_MAX);
        end
        3: begin
          s = LIMIT_MAX;
          e = LIMIT_MAX;
        end
        default: begin
          s = $urandom_range(0, 2000);
          e = $urandom_range(20000, LIMIT_MAX);
        end
      endcase
      write_limit(sjak_pkg::REG_SHOULDER_LIMIT, s);
      write_limit(sjak_pkg::REG_ELBOW_LIMIT, e);
      settings++;
      @(negedge clk);
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        r    = $urandom_range(0, 99);
        bits = {$urandom, $urandom, $urandom};
        j    = bits[$bits(sjak_pkg::joint_t)-1:0];
        mx   = $urandom_range(500, 3595);
        my   = $urandom_range(500, 3595);
        if (r < 55) begin
          // full-range keypoints
        end else if (r < 70) begin
          // tight cluster, short vectors
          j = keypoints(j.kind, mx + $urandom_range(0, 40) - 20, my + $urandom_range(0, 40) - 20,
                        mx, my,
                        mx + $urandom_range(0, 40) - 20, my + $urandom_range(0, 40) - 20);
        end else if (r < 80) begin
          // collinear points, straight or folded back
          dx = $urandom_range(0, 16) - 8;
          dy = $urandom_range(0, 16) - 8;
          a  = $urandom_range(0, 80) - 40;
          b  = $urandom_range(0, 80) - 40;
          j  = keypoints(j.kind, mx + a * dx, my + a * dy, mx, my, mx + b * dx, my + b * dy);
        end else if (r < 90) begin
          // coinciding points
          which = $urandom_range(0, 2);
          case (which)
            0: begin
              j.last_x = j.first_x;
              j.last_y = j.first_y;
            end
            1: begin
              j.middle_x = j.first_x;
              j.middle_y = j.first_y;
            end
            default: begin
              j.last_x = j.middle_x;
              j.last_y = j.middle_y;
            end
          endcase
        end else begin
          // missing keypoints, or a point on an axis
          which = $urandom_range(0, 3);
          case (which)
            0: begin
              j.first_x = '0;
              j.first_y = '0;
            end
            1: begin
              j.middle_x = '0;
              j.middle_y = '0;
            end
            2: begin
              j.last_x = '0;
              j.last_y = '0;
            end
            default: j.first_x = '0;
          endcase
        end
        queue_item(j);
      end
    end

    // drain and allow for any stray result beat
    wait_drained();
    repeat (LATENCY + 8) @(posedge clk);
    $display("checked %0d joint results over %0d limit settings", checked, settings);
    $display("of which %0d missing keypoint, %0d degenerate, %0d clamped",
             n_missing, n_degen, n_clamped);
    if (errors == 0 && angle_due.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
